### design/flyreg_pkg.sv
// ----------------------------------------------------------------------------
// Flywheel regulator package
// Shared item codes, phase encoding, configuration and queue entry types.
// ----------------------------------------------------------------------------
package flyreg_pkg;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_STOP   = 2'd2;

    localparam logic [1:0] CFG_SPINUP_TARGET = 2'd0;
    localparam logic [1:0] CFG_TARGET_TRIM   = 2'd1;
    localparam logic [1:0] CFG_DEADBAND      = 2'd2;

    localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_CODE_SPIN = 2'd1;
    localparam logic [1:0] PHASE_CODE_REG  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SPIN = 3'b010,
        PH_REG  = 3'b100
    } phase_t;

    typedef struct packed {
        logic        [11:0] spinup_target;
        logic signed [10:0] target_trim;
        logic        [7:0]  deadband;
    } cfg_t;

    typedef struct packed {
        logic        [1:0]  kind;
        logic signed [19:0] rpm;
        logic        [12:0] target;
        logic               spin_low;
        logic               reg_low;
        logic               reg_high;
        logic        [9:0]  quot;
    } entry_t;

endpackage

### design/flyreg_front.sv
// ----------------------------------------------------------------------------
// Flywheel regulator front end
// Accept items, convert encoder velocity to rpm, pick the banded target and
// classify each sample against the spin-up and regulation thresholds.
// ----------------------------------------------------------------------------
module flyreg_front (
    input  logic                clk,
    input  logic                rst_n,
    input  flyreg_pkg::cfg_t    cfg,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          kind,
    input  logic signed [15:0]  velocity_raw,
    input  logic signed [15:0]  position_x,
    output logic                q_push,
    output flyreg_pkg::entry_t  q_data,
    input  logic                q_full
);

    localparam logic signed [16:0] RPM_MUL   = 17'sd36112;
    localparam logic        [16:0] DIV15_MUL = 17'd69906;

    logic                a_valid_reg;
    logic                a_valid_next;
    logic [1:0]          a_kind_reg;
    logic signed [19:0]  a_rpm_reg;
    logic [12:0]         a_target_reg;
    logic                a_ready;
    logic                take;
    logic signed [16:0]  neg_vel;
    logic signed [33:0]  rpm_prod;
    logic [10:0]         band;
    logic signed [13:0]  target_sum;
    logic signed [21:0]  rpm_w;
    logic signed [21:0]  t16;
    logic signed [21:0]  db16;
    logic signed [21:0]  spin16;
    logic signed [21:0]  diff;
    logic [13:0]         diff_div32;
    logic [30:0]         quot_prod;

    assign a_ready = !a_valid_reg || !q_full;
    assign full    = !a_ready;
    assign take    = push && a_ready;

    assign neg_vel  = -{velocity_raw[15], velocity_raw};
    assign rpm_prod = neg_vel * RPM_MUL;

    always_comb
    begin
        if (position_x < 16'sd320)
            band = 11'd1850;
        else if (position_x < 16'sd640)
            band = 11'd1750;
        else if (position_x < 16'sd960)
            band = 11'd1650;
        else
            band = 11'd1550;
    end

    assign target_sum = $signed({3'b000, band}) + 14'(cfg.target_trim);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (take)
            a_valid_next = 1'b1;
        else if (q_push)
            a_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_kind_reg   <= kind;
            a_rpm_reg    <= rpm_prod[31:12];
            a_target_reg <= target_sum[12:0];
        end
    end

    assign rpm_w      = 22'(a_rpm_reg);
    assign t16        = $signed({5'b00000, a_target_reg, 4'b0000});
    assign db16       = $signed({10'd0, cfg.deadband, 4'b0000});
    assign spin16     = $signed({6'd0, cfg.spinup_target, 4'b0000});
    assign diff       = t16 - rpm_w;
    assign diff_div32 = diff[18:5];
    assign quot_prod  = 31'(diff_div32) * 31'(DIV15_MUL);

    assign q_push = a_valid_reg && !q_full;

    always_comb
    begin
        q_data.kind     = a_kind_reg;
        q_data.rpm      = a_rpm_reg;
        q_data.target   = a_target_reg;
        q_data.spin_low = rpm_w < spin16;
        q_data.reg_low  = rpm_w < (t16 - db16);
        q_data.reg_high = rpm_w > (t16 + db16);
        q_data.quot     = quot_prod[29:20];
    end

endmodule

### design/flyreg_queue.sv
// ----------------------------------------------------------------------------
// Flywheel regulator item queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module flyreg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  flyreg_pkg::entry_t  wr_data,
    output logic                q_full,
    input  logic                rd_en,
    output logic                q_empty,
    output flyreg_pkg::entry_t  rd_data
);

    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    flyreg_pkg::entry_t  slot0_reg;
    flyreg_pkg::entry_t  slot1_reg;
    logic                do_wr;
    logic                do_rd;

    assign q_full  = count_reg == 2'd2;
    assign q_empty = count_reg == 2'd0;
    assign rd_data = slot0_reg;
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (do_rd)
        begin
            if (do_wr && count_reg == 2'd1)
                slot0_reg <= wr_data;
            else
                slot0_reg <= slot1_reg;
            if (do_wr && count_reg == 2'd2)
                slot1_reg <= wr_data;
        end
        else if (do_wr)
        begin
            if (count_reg == 2'd0)
                slot0_reg <= wr_data;
            else
                slot1_reg <= wr_data;
        end
    end

endmodule

### design/flyreg_back.sv
// ----------------------------------------------------------------------------
// Flywheel regulator back end
// Apply classified items to the phase and drive level and hold the result.
// ----------------------------------------------------------------------------
module flyreg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [11:0]         spinup_target,
    input  logic                q_empty,
    input  flyreg_pkg::entry_t  q_data,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output logic signed [7:0]   drive,
    output logic signed [19:0]  measured_rpm,
    output logic [12:0]         target_rpm,
    output logic                ready_res,
    output logic [1:0]          phase_now
);

    flyreg_pkg::phase_t  phase_reg;
    flyreg_pkg::phase_t  phase_next;
    logic signed [7:0]   speed_reg;
    logic signed [7:0]   speed_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [12:0]         target_next;
    logic                ready_next;
    logic [1:0]          code_next;
    logic signed [11:0]  sum;
    logic signed [7:0]   drive_reg;
    logic signed [19:0]  rpm_reg;
    logic [12:0]         target_reg;
    logic                ready_reg;
    logic [1:0]          code_reg;

    assign q_pop = !q_empty && (!out_valid_reg || pop);

    always_comb
    begin
        phase_next = phase_reg;
        speed_next = speed_reg;
        ready_next = 1'b0;
        sum        = 12'sd0;
        case (q_data.kind)
            flyreg_pkg::KIND_START:
            begin
                speed_next = 8'sd30;
                phase_next = flyreg_pkg::PH_SPIN;
            end
            flyreg_pkg::KIND_STOP:
            begin
                speed_next = 8'sd0;
                phase_next = flyreg_pkg::PH_IDLE;
            end
            flyreg_pkg::KIND_SAMPLE:
            begin
                case (phase_reg)
                    flyreg_pkg::PH_SPIN:
                    begin
                        if (q_data.spin_low)
                        begin
                            sum = 12'(speed_reg) + 12'sd10;
                            if (sum > 12'sd120)
                                speed_next = 8'sd127;
                            else if (sum < -12'sd127)
                                speed_next = -8'sd127;
                            else
                                speed_next = sum[7:0];
                        end
                        else
                            phase_next = flyreg_pkg::PH_REG;
                    end
                    flyreg_pkg::PH_REG:
                    begin
                        if (q_data.reg_low)
                            sum = 12'(speed_reg) + $signed({2'b00, q_data.quot});
                        else if (q_data.reg_high)
                            sum = 12'(speed_reg) - 12'sd1;
                        else
                        begin
                            sum        = 12'(speed_reg);
                            ready_next = 1'b1;
                        end
                        if (sum > 12'sd127)
                            speed_next = 8'sd127;
                        else if (sum < -12'sd127)
                            speed_next = -8'sd127;
                        else
                            speed_next = sum[7:0];
                    end
                    default:
                    begin
                        speed_next = speed_reg;
                    end
                endcase
            end
            default:
            begin
                speed_next = speed_reg;
            end
        endcase
    end

    always_comb
    begin
        case (phase_next)
            flyreg_pkg::PH_SPIN:
            begin
                target_next = {1'b0, spinup_target};
                code_next   = flyreg_pkg::PHASE_CODE_SPIN;
            end
            flyreg_pkg::PH_REG:
            begin
                target_next = q_data.target;
                code_next   = flyreg_pkg::PHASE_CODE_REG;
            end
            default:
            begin
                target_next = 13'd0;
                code_next   = flyreg_pkg::PHASE_CODE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= flyreg_pkg::PH_IDLE;
            speed_reg     <= 8'sd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                phase_reg <= phase_next;
                speed_reg <= speed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            drive_reg  <= speed_next;
            rpm_reg    <= q_data.rpm;
            target_reg <= target_next;
            ready_reg  <= ready_next;
            code_reg   <= code_next;
        end
    end

    assign empty        = !out_valid_reg;
    assign drive        = drive_reg;
    assign measured_rpm = rpm_reg;
    assign target_rpm   = target_reg;
    assign ready_res    = ready_reg;
    assign phase_now    = code_reg;

endmodule

### design/flywheel_speed_regulator.sv
// ----------------------------------------------------------------------------
// Flywheel speed regulator
// Sustains one item per clock while results are popped; else the queue fills
// and full holds off push. A pushed item passes the rpm multiply and target
// banding, then classification and entry into the two-entry queue, then the
// back-end drive-level update, whose phase and speed registers load per pop.
// ----------------------------------------------------------------------------
module flywheel_speed_regulator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [11:0]         cfg_data,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          kind,
    input  logic signed [15:0]  velocity_raw,
    input  logic signed [15:0]  position_x,
    input  logic                pop,
    output logic                empty,
    output logic signed [7:0]   drive,
    output logic signed [19:0]  measured_rpm,
    output logic [12:0]         target_rpm,
    output logic                ready_res,
    output logic [1:0]          phase_now
);

    flyreg_pkg::cfg_t    cfg_reg;
    flyreg_pkg::entry_t  wr_entry;
    flyreg_pkg::entry_t  rd_entry;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spinup_target <= 12'd1850;
            cfg_reg.target_trim   <= 11'sd0;
            cfg_reg.deadband      <= 8'd40;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                flyreg_pkg::CFG_SPINUP_TARGET: cfg_reg.spinup_target <= cfg_data;
                flyreg_pkg::CFG_TARGET_TRIM:   cfg_reg.target_trim   <= cfg_data[10:0];
                flyreg_pkg::CFG_DEADBAND:      cfg_reg.deadband      <= cfg_data[7:0];
                default:                       cfg_reg               <= cfg_reg;
            endcase
        end
    end

    flyreg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .velocity_raw (velocity_raw),
        .position_x   (position_x),
        .q_push       (q_push),
        .q_data       (wr_entry),
        .q_full       (q_full)
    );

    flyreg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (wr_entry),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_data (rd_entry)
    );

    flyreg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .spinup_target (cfg_reg.spinup_target),
        .q_empty       (q_empty),
        .q_data        (rd_entry),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .drive         (drive),
        .measured_rpm  (measured_rpm),
        .target_rpm    (target_rpm),
        .ready_res     (ready_res),
        .phase_now     (phase_now)
    );

    a_ready_in_reg : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && ready_res) |-> (phase_now == flyreg_pkg::PHASE_CODE_REG))
        else $error("ready set outside regulation");

    a_idle_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && phase_now == flyreg_pkg::PHASE_CODE_IDLE)
            |-> (drive == 8'sd0 && target_rpm == 13'd0))
        else $error("idle result with nonzero drive or target");

    a_pop_drains : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && q_empty) |=> empty)
        else $error("result repeated after pop");

endmodule
